[hw/rtl/pgad_pkg.sv]
// package for the presence and growth anomaly detector
// holds register indexes, reset values, shared structs and the night window function
// depends on nothing
`default_nettype none

package pgad_pkg;

   localparam int unsigned HOUR_W      = 5;
   localparam int unsigned PCT_W       = 8;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam int unsigned REQ_COUNT_W = 16;
   localparam int unsigned RSP_COUNT_W = 16;
   localparam int unsigned PCT_SCALE_W = 7;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_START    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_END      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH_PERCENT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_RND      = 3'd3;

   // register reset values
   localparam logic [HOUR_W-1:0] NIGHT_START_RST    = 5'd0;
   localparam logic [HOUR_W-1:0] NIGHT_END_RST      = 5'd6;
   localparam logic [PCT_W-1:0]  GROWTH_PERCENT_RST = 8'd50;
   localparam logic              ALERT_RND_RST      = 1'b0;

   // percent scale used in the growth compare
   localparam logic [PCT_SCALE_W-1:0] PCT_SCALE = 7'd100;

   // item kinds
   localparam logic KIND_DEVICE = 1'b0;
   localparam logic KIND_PASS   = 1'b1;

   typedef struct packed {
      logic [HOUR_W-1:0] night_start;
      logic [HOUR_W-1:0] night_end;
      logic [PCT_W-1:0]  growth_percent;
      logic              alert_on_randomized;
   } cfg_type;

   typedef struct packed {
      logic [HOUR_W-1:0] hour_of_day;
      logic              is_online;
      logic              already_announced;
      logic              online_last_pass;
      logic              mac_randomized;
      logic              vendor_known;
   } dev_in_type;

   typedef struct packed {
      logic new_device_event;
      logic new_device_warning;
      logic night_activity_event;
      logic unknown_vendor_event;
      logic missing_event;
      logic returned_event;
      logic announced_next;
      logic online_last_pass_next;
   } dev_out_type;

   // empty when bounds match, wraps past midnight when end is below start
   function automatic logic hour_in_night(input logic [HOUR_W-1:0] h,
                                          input logic [HOUR_W-1:0] s,
                                          input logic [HOUR_W-1:0] e);
      logic r;
      if (s == e) begin
         r = 1'b0;
      end else if (s < e) begin
         r = (h >= s) && (h < e);
      end else begin
         r = (h >= s) || (h < e);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/pgad_cfg.sv]
// configuration registers of the anomaly detector
// plain write port decoded into a cfg_type struct; uses pgad_pkg
`default_nettype none

module pgad_cfg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [pgad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pgad_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output pgad_pkg::cfg_type                      cfg
);

   pgad_pkg::cfg_type cfg_ff;
   pgad_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pgad_pkg::CSR_NIGHT_START: cfg_in.night_start = csr_wdata[pgad_pkg::HOUR_W-1:0];
            pgad_pkg::CSR_NIGHT_END:   cfg_in.night_end   = csr_wdata[pgad_pkg::HOUR_W-1:0];
            pgad_pkg::CSR_GROWTH_PERCENT:
               cfg_in.growth_percent = csr_wdata[pgad_pkg::PCT_W-1:0];
            pgad_pkg::CSR_ALERT_RND:   cfg_in.alert_on_randomized = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.night_start         <= pgad_pkg::NIGHT_START_RST;
         cfg_ff.night_end           <= pgad_pkg::NIGHT_END_RST;
         cfg_ff.growth_percent      <= pgad_pkg::GROWTH_PERCENT_RST;
         cfg_ff.alert_on_randomized <= pgad_pkg::ALERT_RND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/pgad_dev.sv]
// device record classifier: new, night, unknown vendor, missing, returned
// pure combinational; uses pgad_pkg
`default_nettype none

module pgad_dev (
   input  wire logic                 kind,
   input  wire pgad_pkg::cfg_type    cfg,
   input  wire pgad_pkg::dev_in_type dev_in,
   output pgad_pkg::dev_out_type     dev_out
);

   logic is_new;
   logic night;
   logic announce;

   always_comb begin
      is_new   = !dev_in.already_announced && dev_in.is_online;
      night    = pgad_pkg::hour_in_night(dev_in.hour_of_day, cfg.night_start, cfg.night_end);
      // randomized macs stay quiet unless enabled
      announce = !(dev_in.mac_randomized && !cfg.alert_on_randomized);
      dev_out  = '0;
      if (kind == pgad_pkg::KIND_DEVICE) begin
         if (is_new) begin
            dev_out.new_device_event     = announce;
            dev_out.new_device_warning   = announce && night;
            dev_out.night_activity_event = announce && night;
            dev_out.unknown_vendor_event = announce && !dev_in.mac_randomized
                                           && !dev_in.vendor_known;
            dev_out.announced_next        = 1'b1;
            dev_out.online_last_pass_next = 1'b1;
         end else begin
            dev_out.missing_event  = dev_in.online_last_pass && !dev_in.is_online;
            dev_out.returned_event = !dev_in.online_last_pass && dev_in.is_online;
            dev_out.announced_next        = dev_in.already_announced;
            dev_out.online_last_pass_next = dev_in.is_online;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/pgad_base.sv]
// online count baseline: priming, growth compare and quarter-step tracking
// holds the baseline state; uses pgad_pkg
`default_nettype none

module pgad_base #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_go,
   input  wire logic                          is_pass,
   input  wire logic [COUNT_WIDTH-1:0]        count,
   input  wire logic [pgad_pkg::PCT_W-1:0]    growth_percent,
   output logic                               growth,
   output logic [COUNT_WIDTH-1:0]             base_after
);

   localparam int unsigned PROD_W = COUNT_WIDTH + pgad_pkg::PCT_W + 1;

   logic [COUNT_WIDTH-1:0]    base_ff;
   logic [COUNT_WIDTH-1:0]    base_in;
   logic                      primed_ff;
   logic                      primed_in;
   logic [pgad_pkg::PCT_W:0]  factor;
   logic [PROD_W-1:0]         lhs;
   logic [PROD_W-1:0]         rhs;
   logic                      grew;
   logic signed [COUNT_WIDTH:0] diff;
   logic signed [COUNT_WIDTH:0] step;
   logic [COUNT_WIDTH:0]      sum;
   logic [COUNT_WIDTH-1:0]    next_base;

   always_comb begin
      factor = (pgad_pkg::PCT_W + 1)'(pgad_pkg::PCT_SCALE) + {1'b0, growth_percent};
      lhs    = PROD_W'(count) * PROD_W'(pgad_pkg::PCT_SCALE);
      rhs    = PROD_W'(base_ff) * PROD_W'(factor);
      grew   = primed_ff && (base_ff != '0) && (count > base_ff) && (lhs >= rhs);

      // quarter step, truncated toward zero
      diff = $signed({1'b0, count}) - $signed({1'b0, base_ff});
      step = diff >>> 2;
      if (diff[COUNT_WIDTH] && (diff[1:0] != 2'b00)) begin
         step = step + (COUNT_WIDTH + 1)'(1);
      end
      sum = {1'b0, base_ff} + $unsigned(step);

      next_base  = primed_ff ? sum[COUNT_WIDTH-1:0] : count;
      growth     = is_pass && grew;
      base_after = is_pass ? next_base : base_ff;

      base_in   = base_ff;
      primed_in = primed_ff;
      if (item_go && is_pass) begin
         base_in   = next_base;
         primed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         primed_ff <= 1'b0;
      end else begin
         base_ff   <= base_in;
         primed_ff <= primed_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/presence_and_growth_anomaly_detector.sv]
// top level of the presence and growth anomaly detector
// instantiates pgad_cfg, pgad_dev and pgad_base; uses pgad_pkg
// usage
//   req_* carries one item: a device status record (kind 0) or an end of
//   pass with the online count (kind 1). rsp_* returns exactly one result
//   item for every accepted item, in order. both channels use valid/stall:
//   an item moves at a rising edge with valid high and stall low.
//   csr_* writes the four registers (night start, night end, growth percent,
//   randomized alert); write only while no item is in flight.
// timing
//   an accepted item waits in the input register, and its result is loaded
//   into the result register once that is free, which raises rsp_valid.
//   one item per cycle is sustained while rsp_stall stays low; a pass item
//   sees the baseline left by the one before it.
// stall
//   with rsp_stall high the result holds; the input register still takes
//   one item, and req_stall rises only once both registers are full.
// reset
//   registers go to their defaults (night 0 to 6, growth 50, randomized off),
//   the baseline to zero and unprimed, and both stages to empty.
`default_nettype none

module presence_and_growth_anomaly_detector #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration port
   input  wire logic                                  csr_wr_en,
   input  wire logic [pgad_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [pgad_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // item input
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_kind,
   input  wire logic [pgad_pkg::HOUR_W-1:0]           req_hour_of_day,
   input  wire logic                                  req_is_online,
   input  wire logic                                  req_already_announced,
   input  wire logic                                  req_online_last_pass,
   input  wire logic                                  req_mac_randomized,
   input  wire logic                                  req_vendor_known,
   input  wire logic [pgad_pkg::REQ_COUNT_W-1:0]      req_online_count,
   // result output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_new_device_event,
   output logic                                       rsp_new_device_warning,
   output logic                                       rsp_night_activity_event,
   output logic                                       rsp_unknown_vendor_event,
   output logic                                       rsp_missing_event,
   output logic                                       rsp_returned_event,
   output logic                                       rsp_growth_event,
   output logic                                       rsp_announced_next,
   output logic                                       rsp_online_last_pass_next,
   output logic [pgad_pkg::RSP_COUNT_W-1:0]           rsp_baseline_now
);

   pgad_pkg::cfg_type      cfg;

   // input register
   logic                   s1_vld_ff;
   logic                   s1_vld_in;
   logic                   s1_kind_ff;
   pgad_pkg::dev_in_type   s1_dev_ff;
   logic [COUNT_WIDTH-1:0] s1_count_ff;

   // result register
   logic                   rsp_vld_ff;
   logic                   rsp_vld_in;
   pgad_pkg::dev_out_type  rsp_dev_ff;
   logic                   rsp_growth_ff;
   logic [pgad_pkg::RSP_COUNT_W-1:0] rsp_base_ff;

   // handshake
   logic                   req_take;
   logic                   s1_move;
   logic                   out_free;

   pgad_pkg::dev_out_type  dev_out;
   logic                   growth;
   logic [COUNT_WIDTH-1:0] base_after;

   pgad_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pgad_dev u_dev (
      .kind    (s1_kind_ff),
      .cfg     (cfg),
      .dev_in  (s1_dev_ff),
      .dev_out (dev_out)
   );

   pgad_base #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_base (
      .clock          (clock),
      .reset          (reset),
      .item_go        (s1_move),
      .is_pass        (s1_kind_ff == pgad_pkg::KIND_PASS),
      .count          (s1_count_ff),
      .growth_percent (cfg.growth_percent),
      .growth         (growth),
      .base_after     (base_after)
   );

   // result register frees up when empty or being taken this cycle
   always_comb begin
      out_free   = !rsp_vld_ff || !rsp_stall;
      s1_move    = s1_vld_ff && out_free;
      req_stall  = s1_vld_ff && !out_free;
      req_take   = req_valid && !req_stall;
      s1_vld_in  = req_take || (s1_vld_ff && !s1_move);
      rsp_vld_in = s1_move || (rsp_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff                  <= req_kind;
         s1_dev_ff.hour_of_day       <= req_hour_of_day;
         s1_dev_ff.is_online         <= req_is_online;
         s1_dev_ff.already_announced <= req_already_announced;
         s1_dev_ff.online_last_pass  <= req_online_last_pass;
         s1_dev_ff.mac_randomized    <= req_mac_randomized;
         s1_dev_ff.vendor_known      <= req_vendor_known;
         s1_count_ff                 <= COUNT_WIDTH'(req_online_count);
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_dev_ff    <= dev_out;
         rsp_growth_ff <= growth;
         rsp_base_ff   <= pgad_pkg::RSP_COUNT_W'(base_after);
      end
   end

   assign rsp_valid                 = rsp_vld_ff;
   assign rsp_new_device_event      = rsp_dev_ff.new_device_event;
   assign rsp_new_device_warning    = rsp_dev_ff.new_device_warning;
   assign rsp_night_activity_event  = rsp_dev_ff.night_activity_event;
   assign rsp_unknown_vendor_event  = rsp_dev_ff.unknown_vendor_event;
   assign rsp_missing_event         = rsp_dev_ff.missing_event;
   assign rsp_returned_event        = rsp_dev_ff.returned_event;
   assign rsp_growth_event          = rsp_growth_ff;
   assign rsp_announced_next        = rsp_dev_ff.announced_next;
   assign rsp_online_last_pass_next = rsp_dev_ff.online_last_pass_next;
   assign rsp_baseline_now          = rsp_base_ff;

endmodule

`default_nettype wire

[hw/rtl/pgad_checker.sv]
// port-level checks for the anomaly detector, bound to the top level
// sees only the top level's ports; uses pgad_pkg
`default_nettype none

module pgad_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic                                  rsp_new_device_event,
   input wire logic                                  rsp_new_device_warning,
   input wire logic                                  rsp_night_activity_event,
   input wire logic                                  rsp_unknown_vendor_event,
   input wire logic                                  rsp_missing_event,
   input wire logic                                  rsp_returned_event,
   input wire logic                                  rsp_growth_event,
   input wire logic                                  rsp_announced_next,
   input wire logic                                  rsp_online_last_pass_next,
   input wire logic [pgad_pkg::RSP_COUNT_W-1:0]      rsp_baseline_now
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_baseline_now)
                                 && $stable(rsp_growth_event))
      else $error("result changed while stalled");

   // warning severity and night activity go together; they and unknown vendor need a new device
   a_night_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_device_warning == rsp_night_activity_event)
                    && (!rsp_new_device_warning || rsp_new_device_event)
                    && (!rsp_unknown_vendor_event || rsp_new_device_event))
      else $error("night or vendor flag without a new device");

   // a new device is stored back as announced and online
   a_new_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_device_event |-> rsp_announced_next && rsp_online_last_pass_next
                                            && !rsp_missing_event && !rsp_returned_event)
      else $error("new device stored back wrongly");

   // growth only comes from a pass item, which carries no device flags
   a_growth_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_growth_event |-> !rsp_announced_next && !rsp_online_last_pass_next
                                        && !rsp_new_device_event && !rsp_missing_event
                                        && !rsp_returned_event)
      else $error("growth flagged on a device record");

   // with an empty result register no stall reaches the input side
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while result register empty");

endmodule

bind presence_and_growth_anomaly_detector pgad_checker u_pgad_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the presence and growth anomaly detector
// predicts every result from its own copy of the baseline and registers, checks it in order
// depends on pgad_pkg and presence_and_growth_anomaly_detector
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int TAIL_CYCLES     = 6;
   localparam int SETTLE_CYCLES   = 4;
   localparam int REPORT_LIMIT    = 10;

   // one status item as it crosses the request port
   typedef struct packed {
      logic                             kind;
      logic [pgad_pkg::HOUR_W-1:0]      hour;
      logic                             online;
      logic                             announced;
      logic                             prev_online;
      logic                             randomized;
      logic                             vendor_known;
      logic [pgad_pkg::REQ_COUNT_W-1:0] count;
   } status_item_type;

   // the flags and baseline that come back for one item
   typedef struct packed {
      logic                             new_device;
      logic                             warning;
      logic                             night_activity;
      logic                             unknown_vendor;
      logic                             missing;
      logic                             returned;
      logic                             growth;
      logic                             announced_next;
      logic                             online_next;
      logic [pgad_pkg::RSP_COUNT_W-1:0] baseline;
   } alert_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_wr_en = 1'b0;
   logic [pgad_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pgad_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic                             req_valid             = 1'b0;
   logic                             req_stall;
   logic                             req_kind              = pgad_pkg::KIND_DEVICE;
   logic [pgad_pkg::HOUR_W-1:0]      req_hour_of_day       = '0;
   logic                             req_is_online         = 1'b0;
   logic                             req_already_announced = 1'b0;
   logic                             req_online_last_pass  = 1'b0;
   logic                             req_mac_randomized    = 1'b0;
   logic                             req_vendor_known      = 1'b0;
   logic [pgad_pkg::REQ_COUNT_W-1:0] req_online_count      = '0;

   logic                             rsp_valid;
   logic                             rsp_stall = 1'b1;
   logic                             rsp_new_device_event;
   logic                             rsp_new_device_warning;
   logic                             rsp_night_activity_event;
   logic                             rsp_unknown_vendor_event;
   logic                             rsp_missing_event;
   logic                             rsp_returned_event;
   logic                             rsp_growth_event;
   logic                             rsp_announced_next;
   logic                             rsp_online_last_pass_next;
   logic [pgad_pkg::RSP_COUNT_W-1:0] rsp_baseline_now;

   presence_and_growth_anomaly_detector u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .csr_wr_en                 (csr_wr_en),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_kind                  (req_kind),
      .req_hour_of_day           (req_hour_of_day),
      .req_is_online             (req_is_online),
      .req_already_announced     (req_already_announced),
      .req_online_last_pass      (req_online_last_pass),
      .req_mac_randomized        (req_mac_randomized),
      .req_vendor_known          (req_vendor_known),
      .req_online_count          (req_online_count),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_new_device_event      (rsp_new_device_event),
      .rsp_new_device_warning    (rsp_new_device_warning),
      .rsp_night_activity_event  (rsp_night_activity_event),
      .rsp_unknown_vendor_event  (rsp_unknown_vendor_event),
      .rsp_missing_event         (rsp_missing_event),
      .rsp_returned_event        (rsp_returned_event),
      .rsp_growth_event          (rsp_growth_event),
      .rsp_announced_next        (rsp_announced_next),
      .rsp_online_last_pass_next (rsp_online_last_pass_next),
      .rsp_baseline_now          (rsp_baseline_now)
   );

   // predictor copy of the registers, written alongside the csr port
   logic [pgad_pkg::HOUR_W-1:0] night_lo     = pgad_pkg::NIGHT_START_RST;
   logic [pgad_pkg::HOUR_W-1:0] night_hi     = pgad_pkg::NIGHT_END_RST;
   logic [pgad_pkg::PCT_W-1:0]  rise_pct     = pgad_pkg::GROWTH_PERCENT_RST;
   logic                        announce_rnd = pgad_pkg::ALERT_RND_RST;

   // predictor copy of the running baseline
   logic [pgad_pkg::RSP_COUNT_W-1:0] model_baseline = '0;
   logic                             model_primed   = 1'b0;

   alert_set_type pending_alerts[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off_req  = 1'b0;
   int hold_left     = 0;
   int errors        = 0;
   int result_index  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // night window: empty when bounds match, wraps past midnight when end < start
   function automatic logic in_night_window(input logic [pgad_pkg::HOUR_W-1:0] h);
      if (night_lo == night_hi) begin
         return 1'b0;
      end else if (night_lo < night_hi) begin
         return (h >= night_lo) && (h < night_hi);
      end else begin
         return (h >= night_lo) || (h < night_hi);
      end
   endfunction

   // works out the result of one accepted item and advances the baseline
   function automatic alert_set_type predict_alerts(input status_item_type it);
      alert_set_type a;
      logic          night;
      longint        base;
      longint        cnt;
      longint        step;
      a     = '0;
      night = in_night_window(it.hour);
      base  = model_baseline;
      cnt   = it.count;
      if (it.kind == pgad_pkg::KIND_DEVICE) begin
         if (!it.announced && it.online) begin
            // randomized macs stay quiet unless enabled, but are still marked announced
            if (!(it.randomized && !announce_rnd)) begin
               a.new_device     = 1'b1;
               a.warning        = night;
               a.night_activity = night;
               a.unknown_vendor = !it.randomized && !it.vendor_known;
            end
            a.announced_next = 1'b1;
            a.online_next    = 1'b1;
         end else begin
            a.missing        = it.prev_online && !it.online;
            a.returned       = !it.prev_online && it.online;
            a.announced_next = it.announced;
            a.online_next    = it.online;
         end
      end else if (!model_primed) begin
         // first end of scan only loads the baseline
         model_baseline = it.count;
         model_primed   = 1'b1;
      end else begin
         a.growth = (base != 0) && (cnt > base) &&
                    (cnt * 100 >= base * (100 + longint'(rise_pct)));
         // quarter step toward the count, division truncates toward zero
         step = (cnt - base) / 4;
         model_baseline = pgad_pkg::RSP_COUNT_W'(base + step);
      end
      a.baseline = model_baseline;
      return a;
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("result %0d field %s: expected %0d, got %0d",
                     result_index, name, want, got);
      end
   endtask

   task automatic compare_alerts(input alert_set_type want, input alert_set_type got);
      check_field("new_device_event", want.new_device, got.new_device);
      check_field("new_device_warning", want.warning, got.warning);
      check_field("night_activity_event", want.night_activity, got.night_activity);
      check_field("unknown_vendor_event", want.unknown_vendor, got.unknown_vendor);
      check_field("missing_event", want.missing, got.missing);
      check_field("returned_event", want.returned, got.returned);
      check_field("growth_event", want.growth, got.growth);
      check_field("announced_next", want.announced_next, got.announced_next);
      check_field("online_last_pass_next", want.online_next, got.online_next);
      check_field("baseline_now", want.baseline, got.baseline);
   endtask

   // both handshakes sampled at the rising edge; results are checked before
   // the item taken at the same edge is predicted
   always @(posedge clock) begin : monitor
      alert_set_type   seen;
      status_item_type taken;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_new_device_event, rsp_new_device_warning,
                     rsp_night_activity_event, rsp_unknown_vendor_event,
                     rsp_missing_event, rsp_returned_event, rsp_growth_event,
                     rsp_announced_next, rsp_online_last_pass_next, rsp_baseline_now};
            if (pending_alerts.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("result %0d arrived with nothing outstanding", result_index);
            end else begin
               compare_alerts(pending_alerts.pop_front(), seen);
            end
            result_index++;
         end
         if (req_valid && !req_stall) begin
            taken = '{req_kind, req_hour_of_day, req_is_online, req_already_announced,
                      req_online_last_pass, req_mac_randomized, req_vendor_known,
                      req_online_count};
            pending_alerts.push_back(predict_alerts(taken));
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver side: random stall, plus a counted hold-off on request
   // ------------------------------------------------------------------

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog: too many cycles in a row with nothing moving on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------

   // offers one item at the falling edge and holds it until taken
   task automatic send_item(input status_item_type it);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_kind              <= it.kind;
      req_hour_of_day       <= it.hour;
      req_is_online         <= it.online;
      req_already_announced <= it.announced;
      req_online_last_pass  <= it.prev_online;
      req_mac_randomized    <= it.randomized;
      req_vendor_known      <= it.vendor_known;
      req_online_count      <= it.count;
      do @(posedge clock); while (req_stall);
   endtask

   // drops valid and waits until every outstanding result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_alerts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr write, only called with the block idle
   task automatic set_register(input logic [pgad_pkg::CSR_IDX_W-1:0] idx,
                               input logic [pgad_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         pgad_pkg::CSR_NIGHT_START:    night_lo     = value[pgad_pkg::HOUR_W-1:0];
         pgad_pkg::CSR_NIGHT_END:      night_hi     = value[pgad_pkg::HOUR_W-1:0];
         pgad_pkg::CSR_GROWTH_PERCENT: rise_pct     = value[pgad_pkg::PCT_W-1:0];
         pgad_pkg::CSR_ALERT_RND:      announce_rnd = value[0];
         default: ;
      endcase
   endtask

   task automatic set_window(input int first_hour, input int end_hour);
      set_register(pgad_pkg::CSR_NIGHT_START, pgad_pkg::CSR_DATA_W'(first_hour));
      set_register(pgad_pkg::CSR_NIGHT_END, pgad_pkg::CSR_DATA_W'(end_hour));
   endtask

   // device record; the count field carries noise that must be ignored
   function automatic status_item_type device_item(input int hour, input bit online,
                                                   input bit announced, input bit was,
                                                   input bit rnd, input bit vendor);
      status_item_type it;
      it = '{pgad_pkg::KIND_DEVICE, pgad_pkg::HOUR_W'(hour), online, announced, was,
             rnd, vendor, pgad_pkg::REQ_COUNT_W'($urandom)};
      return it;
   endfunction

   // end of scan with the online count; device fields are noise
   function automatic status_item_type count_item(input longint count);
      status_item_type it;
      it = status_item_type'($urandom);
      it.kind  = pgad_pkg::KIND_PASS;
      it.count = pgad_pkg::REQ_COUNT_W'(count);
      return it;
   endfunction

   // random item: mostly device records; pass counts near the threshold, the baseline, zero, the top or anywhere
   function automatic status_item_type random_item();
      status_item_type it;
      longint          base;
      longint          edge_count;
      longint          c;
      it = status_item_type'({$urandom, $urandom});
      if ($urandom_range(3) != 0) begin
         it.kind = pgad_pkg::KIND_DEVICE;
         // lean toward fresh online devices so the announce path gets exercised
         if ($urandom_range(1) == 0) begin
            it.online    = 1'b1;
            it.announced = 1'b0;
         end
         if ($urandom_range(3) != 0) it.hour = pgad_pkg::HOUR_W'($urandom_range(23));
      end else begin
         it.kind    = pgad_pkg::KIND_PASS;
         base       = model_baseline;
         edge_count = (base * (100 + longint'(rise_pct)) + 99) / 100;
         case ($urandom_range(4))
            0: c = $urandom_range(65535);
            1: c = edge_count + longint'($urandom_range(4)) - 2;
            2: c = base + longint'($urandom_range(6)) - 3;
            3: c = $urandom_range(7);
            default: c = 65535 - $urandom_range(3);
         endcase
         if (c < 0) c = 0;
         if (c > 65535) c = 65535;
         it.count = pgad_pkg::REQ_COUNT_W'(c);
      end
      return it;
   endfunction

   // random register settings with the extremes favored
   task automatic randomize_registers();
      int lo;
      int hi;
      int pct;
      lo = ($urandom_range(4) == 0) ? $urandom_range(24, 31) : $urandom_range(23);
      hi = ($urandom_range(4) == 0) ? $urandom_range(24, 31) : $urandom_range(23);
      if ($urandom_range(7) == 0) hi = lo;
      case ($urandom_range(3))
         0: pct = 0;
         1: pct = 255;
         default: pct = $urandom_range(255);
      endcase
      set_window(lo, hi);
      set_register(pgad_pkg::CSR_GROWTH_PERCENT, pgad_pkg::CSR_DATA_W'(pct));
      set_register(pgad_pkg::CSR_ALERT_RND, pgad_pkg::CSR_DATA_W'($urandom_range(1)));
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // baseline priming, zero baseline, equality, extremes and the exact threshold
   // (default growth percent of 50)
   task automatic test_baseline_tracking();
      send_item(count_item(0));       // primes at zero
      send_item(count_item(100));     // zero baseline never grows, moves to 25
      send_item(count_item(25));      // equal to baseline
      send_item(count_item(65535));   // large rise
      send_item(count_item(0));       // fall, negative step truncates toward zero
      wait_drained();
      send_item(count_item((longint'(model_baseline) * 150 + 99) / 100));
      wait_drained();
      send_item(count_item((longint'(model_baseline) * 150 + 99) / 100 - 1));
      send_item(device_item(12, 1, 1, 1, 0, 1));  // baseline must be left alone
   endtask

   // device classification under the reset window of hours 0 to 6
   task automatic test_device_classes();
      send_item(device_item(3, 1, 0, 0, 0, 0));   // new at night, unknown vendor
      send_item(device_item(6, 1, 0, 1, 0, 1));   // window end is exclusive
      send_item(device_item(0, 1, 0, 0, 1, 0));   // randomized mac held back
      send_item(device_item(10, 0, 1, 1, 0, 1));  // missing
      send_item(device_item(10, 1, 1, 0, 0, 1));  // returned
      send_item(device_item(10, 1, 1, 1, 1, 0));  // steady, no event
      send_item(device_item(10, 0, 0, 1, 0, 0));  // never announced and offline
      send_item(device_item(31, 1, 0, 0, 0, 1));  // hour beyond range
      send_item(device_item(23, 1, 0, 0, 0, 0));
   endtask

   // every register, with wrapped, empty and out-of-range windows
   task automatic test_register_settings();
      wait_drained();
      set_window(22, 5);
      set_register(pgad_pkg::CSR_GROWTH_PERCENT, pgad_pkg::CSR_DATA_W'(0));
      set_register(pgad_pkg::CSR_ALERT_RND, pgad_pkg::CSR_DATA_W'(1));
      send_item(device_item(23, 1, 0, 0, 0, 0));
      send_item(device_item(2, 1, 0, 0, 0, 1));
      send_item(device_item(5, 1, 0, 0, 0, 1));
      send_item(device_item(1, 1, 0, 0, 1, 0));   // randomized now announced
      wait_drained();
      send_item(count_item(longint'(model_baseline) + 1));  // any rise is growth
      wait_drained();
      set_window(7, 7);
      set_register(pgad_pkg::CSR_GROWTH_PERCENT, pgad_pkg::CSR_DATA_W'(255));
      send_item(device_item(7, 1, 0, 0, 0, 0));   // empty window
      send_item(count_item(65535));
      wait_drained();
      set_window(30, 24);
      send_item(device_item(27, 1, 0, 0, 0, 1));
      send_item(device_item(31, 1, 0, 0, 0, 1));
      send_item(device_item(3, 1, 0, 0, 0, 1));
   endtask

   // random traffic, registers reshuffled now and then with the block idle
   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 110 == 0) begin
            wait_drained();
            randomize_registers();
         end
         send_item(random_item());
      end
   endtask

   // receiver holds off long enough for both stages to fill and stall the input
   task automatic test_output_holdoff();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req  = 1'b1;
      for (int i = 0; i < 30; i++) send_item(random_item());
   endtask

   // sender stops mid-stream until everything is back, then resumes
   task automatic test_drain_pause();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 40; i++) send_item(random_item());
      wait_drained();
      for (int i = 0; i < 40; i++) send_item(random_item());
   endtask

   initial begin
      send_idle_pct = 29;
      recv_idle_pct = 63;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_baseline_tracking();
      test_device_classes();
      test_register_settings();
      test_random_traffic(330, 29, 63);
      test_random_traffic(330, 63, 29);
      test_output_holdoff();
      test_random_traffic(330, 0, 0);
      test_drain_pause();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_alerts.size() != 0) begin
         errors += pending_alerts.size();
         $display("%0d results never arrived", pending_alerts.size());
      end
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/pgad_pkg.sv
hw/rtl/pgad_cfg.sv
hw/rtl/pgad_dev.sv
hw/rtl/pgad_base.sv
hw/rtl/presence_and_growth_anomaly_detector.sv
hw/rtl/pgad_checker.sv
tb/testbench.sv
